// ===== sv/tehp_pkg.sv =====
package tehp_pkg;

   // configuration port
   localparam int CSR_DATA_BITS  = 24;
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PEDESTAL_RIGHT  = 3'd0,
      CSR_PEDESTAL_LEFT   = 3'd1,
      CSR_TIME_OFFSET     = 3'd2,
      CSR_SPEED           = 3'd3,
      CSR_WRAP_PERIOD     = 3'd4,
      CSR_BAR_LENGTH      = 3'd5,
      CSR_POS_CAL_ENABLE  = 3'd6
   } csr_index_type;

   // register field widths
   localparam int PEDESTAL_BITS = 12;
   localparam int OFFSET_BITS   = 21;
   localparam int SPEED_BITS    = 10;
   localparam int WRAP_BITS     = 21;
   localparam int LENGTH_BITS   = 24;

   // position and calibration watchdog
   localparam int POS_BITS  = 32;
   localparam int FAIL_BITS = 4;
   localparam logic [FAIL_BITS-1:0] MAX_FAILS = 4'd10;
   localparam logic [POS_BITS-1:0]  POS_MAX   = 32'h7FFF_FFFF;
   localparam logic [POS_BITS-1:0]  POS_MIN   = 32'h8000_0000;

   typedef struct packed {
      logic clear;
      logic both_seen;
   } pair_flags_type;

   typedef struct packed {
      logic load;
      logic value;
   } cal_load_type;

   function automatic int max_of(int a, int b);
      return (a > b) ? a : b;
   endfunction

   // left time minus right time minus offset, signed
   function automatic int diff_width(int time_bits);
      return max_of(time_bits + 2, OFFSET_BITS) + 1;
   endfunction

endpackage

// ===== sv/two_ended_bar_hit_position_unit.sv =====
// path: an accepted request passes the input register, the pairing stage register and the result register
// throughput: one transaction per cycle, limited only by rsp_ready
// pipeline: input register, pairing/unwrap stage, position/multiply stage
// reset: synchronous, active high; clears pipeline valids, side flags, fail count,
// last position and calibration state; config registers return to defaults
module two_ended_bar_hit_position_unit
   import tehp_pkg::*;
#(
   parameter int TIME_BITS   = 20,
   parameter int CHARGE_BITS = 12
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_kind,
   input  logic                        req_side,
   input  logic [TIME_BITS-1:0]        req_hit_time_ps,
   input  logic [CHARGE_BITS-1:0]      req_raw_charge,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_both_sides_seen,
   output logic [CHARGE_BITS-1:0]      rsp_corrected_charge,
   output logic signed [POS_BITS-1:0]  rsp_position_um,
   output logic                        rsp_position_updated,
   output logic                        rsp_out_of_range,
   output logic                        rsp_position_cal_active,
   // configuration writes
   input  logic                        csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [CSR_DATA_BITS-1:0]    csr_write_data
);

   localparam int DIFF_BITS = diff_width(TIME_BITS);

   // configuration registers
   logic [PEDESTAL_BITS-1:0]      pedestal_right_ff;
   logic [PEDESTAL_BITS-1:0]      pedestal_left_ff;
   logic signed [OFFSET_BITS-1:0] time_offset_ff;
   logic [SPEED_BITS-1:0]         speed_ff;
   logic [WRAP_BITS-1:0]          wrap_period_ff;
   logic [LENGTH_BITS-1:0]        bar_length_ff;
   cal_load_type                  cal_load;

   // input register
   logic                          in_valid_ff;
   logic                          in_valid_in;
   logic                          kind_ff;
   logic                          side_ff;
   logic [TIME_BITS-1:0]          hit_time_ff;
   logic [CHARGE_BITS-1:0]        raw_charge_ff;

   // pairing stage output
   logic                          pair_valid_ff;
   logic                          pair_valid_in;
   pair_flags_type                pair_flags;
   logic [CHARGE_BITS-1:0]        pair_charge;
   logic signed [DIFF_BITS-1:0]   pair_diff;

   // result register valid
   logic                          out_valid_ff;
   logic                          out_valid_in;

   logic                          load_out;
   logic                          load_pair;
   logic                          accept;

   // each stage moves when the next one is empty or moving
   assign load_out  = !out_valid_ff || rsp_ready;
   assign load_pair = !pair_valid_ff || load_out;
   assign req_ready = !in_valid_ff || load_pair;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;

   always_comb begin
      in_valid_in   = accept ? 1'b1 : (load_pair ? 1'b0 : in_valid_ff);
      pair_valid_in = load_pair ? in_valid_ff : pair_valid_ff;
      out_valid_in  = load_out ? pair_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         pair_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         pair_valid_ff <= pair_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // request payload capture
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff       <= req_kind;
         side_ff       <= req_side;
         hit_time_ff   <= req_hit_time_ps;
         raw_charge_ff <= req_raw_charge;
      end
   end

   // config writes; the calibration enable write loads the active flag directly
   always_ff @(posedge clock) begin
      if (reset) begin
         pedestal_right_ff <= '0;
         pedestal_left_ff  <= '0;
         time_offset_ff    <= '0;
         speed_ff          <= 10'd140;
         wrap_period_ff    <= 21'd1048576;
         bar_length_ff     <= 24'd2700000;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_PEDESTAL_RIGHT: pedestal_right_ff <= csr_write_data[PEDESTAL_BITS-1:0];
            CSR_PEDESTAL_LEFT:  pedestal_left_ff  <= csr_write_data[PEDESTAL_BITS-1:0];
            CSR_TIME_OFFSET:    time_offset_ff    <= signed'(csr_write_data[OFFSET_BITS-1:0]);
            CSR_SPEED:          speed_ff          <= csr_write_data[SPEED_BITS-1:0];
            CSR_WRAP_PERIOD:    wrap_period_ff    <= csr_write_data[WRAP_BITS-1:0];
            CSR_BAR_LENGTH:     bar_length_ff     <= csr_write_data[LENGTH_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cal_load = '{
      load:  csr_write_enable && (csr_index == CSR_POS_CAL_ENABLE),
      value: csr_write_data[0]
   };

   // side pairing, charge correction, time unwrap, time difference
   tehp_pair #(
      .TIME_BITS   (TIME_BITS),
      .CHARGE_BITS (CHARGE_BITS)
   ) u_pair (
      .clock          (clock),
      .reset          (reset),
      .step           (in_valid_ff && load_pair),
      .kind           (kind_ff),
      .side           (side_ff),
      .hit_time       (hit_time_ff),
      .raw_charge     (raw_charge_ff),
      .pedestal_right (pedestal_right_ff),
      .pedestal_left  (pedestal_left_ff),
      .time_offset    (time_offset_ff),
      .wrap_period    (wrap_period_ff),
      .flags_ff       (pair_flags),
      .charge_ff      (pair_charge),
      .diff_ff        (pair_diff)
   );

   // position multiply, saturation, range check, calibration watchdog
   tehp_pos #(
      .TIME_BITS   (TIME_BITS),
      .CHARGE_BITS (CHARGE_BITS)
   ) u_pos (
      .clock                   (clock),
      .reset                   (reset),
      .step                    (pair_valid_ff && load_out),
      .flags                   (pair_flags),
      .charge                  (pair_charge),
      .diff                    (pair_diff),
      .speed                   (speed_ff),
      .bar_length              (bar_length_ff),
      .cal_load                (cal_load),
      .rsp_both_sides_seen     (rsp_both_sides_seen),
      .rsp_corrected_charge    (rsp_corrected_charge),
      .rsp_position_um         (rsp_position_um),
      .rsp_position_updated    (rsp_position_updated),
      .rsp_out_of_range        (rsp_out_of_range),
      .rsp_position_cal_active (rsp_position_cal_active)
   );

endmodule

// ===== sv/tehp_pair.sv =====
module tehp_pair
   import tehp_pkg::*;
#(
   parameter int TIME_BITS   = 20,
   parameter int CHARGE_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic                                kind,
   input  logic                                side,
   input  logic [TIME_BITS-1:0]                hit_time,
   input  logic [CHARGE_BITS-1:0]              raw_charge,
   input  logic [PEDESTAL_BITS-1:0]            pedestal_right,
   input  logic [PEDESTAL_BITS-1:0]            pedestal_left,
   input  logic signed [OFFSET_BITS-1:0]       time_offset,
   input  logic [WRAP_BITS-1:0]                wrap_period,
   output pair_flags_type                      flags_ff,
   output logic [CHARGE_BITS-1:0]              charge_ff,
   output logic signed [diff_width(TIME_BITS)-1:0] diff_ff
);

   localparam int ST_BITS   = TIME_BITS + 1;
   localparam int CMP_BITS  = max_of(TIME_BITS + 2, WRAP_BITS);
   localparam int SUM_BITS  = max_of(ST_BITS, WRAP_BITS) + 1;
   localparam int DIFF_BITS = diff_width(TIME_BITS);
   localparam int Q_BITS    = max_of(CHARGE_BITS, PEDESTAL_BITS);

   logic [1:0]                 seen_ff;
   logic [1:0]                 seen_in;
   logic [ST_BITS-1:0]         time_store_ff [2];
   logic [PEDESTAL_BITS-1:0]   pedestal;
   logic [Q_BITS-1:0]          q_ext;
   logic [Q_BITS-1:0]          p_ext;
   logic [CHARGE_BITS-1:0]     charge;
   logic [ST_BITS-1:0]         tl;
   logic [ST_BITS-1:0]         tr;
   logic [ST_BITS-1:0]         gap;
   logic [ST_BITS:0]           twice;
   logic                       wrap_hit;
   logic [ST_BITS-1:0]         tl_fix;
   logic [ST_BITS-1:0]         tr_fix;
   logic signed [DIFF_BITS-1:0] diff;
   logic                       both;

   always_comb begin
      pedestal = side ? pedestal_left : pedestal_right;
      q_ext    = Q_BITS'(raw_charge);
      p_ext    = Q_BITS'(pedestal);
      if (q_ext > p_ext) begin
         charge = CHARGE_BITS'(q_ext - p_ext);
      end else begin
         charge = CHARGE_BITS'(1);
      end

      seen_in = seen_ff | (side ? 2'b10 : 2'b01);
      both    = (seen_in == 2'b11);

      // the new hit replaces its own side before pairing
      tl = side ? ST_BITS'(hit_time) : time_store_ff[1];
      tr = side ? time_store_ff[0] : ST_BITS'(hit_time);

      if (tl > tr) begin
         gap = tl - tr;
      end else begin
         gap = tr - tl;
      end
      twice    = {gap, 1'b0};
      wrap_hit = CMP_BITS'(twice) > CMP_BITS'(wrap_period);

      // unwrap by moving the earlier time up one period
      tl_fix = tl;
      tr_fix = tr;
      if (wrap_hit) begin
         if (tl < tr) begin
            tl_fix = ST_BITS'(SUM_BITS'(tl) + SUM_BITS'(wrap_period));
         end else begin
            tr_fix = ST_BITS'(SUM_BITS'(tr) + SUM_BITS'(wrap_period));
         end
      end

      diff = DIFF_BITS'(tl_fix) - DIFF_BITS'(tr_fix) - DIFF_BITS'(time_offset);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 2'b00;
      end else if (step) begin
         seen_ff <= kind ? 2'b00 : seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && !kind) begin
         if (both) begin
            time_store_ff[1] <= tl_fix;
            time_store_ff[0] <= tr_fix;
         end else begin
            time_store_ff[side] <= ST_BITS'(hit_time);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         flags_ff.clear     <= kind;
         flags_ff.both_seen <= !kind && both;
         charge_ff          <= kind ? '0 : charge;
         diff_ff            <= diff;
      end
   end

endmodule

// ===== sv/tehp_pos.sv =====
module tehp_pos
   import tehp_pkg::*;
#(
   parameter int TIME_BITS   = 20,
   parameter int CHARGE_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  pair_flags_type                      flags,
   input  logic [CHARGE_BITS-1:0]              charge,
   input  logic signed [diff_width(TIME_BITS)-1:0] diff,
   input  logic [SPEED_BITS-1:0]               speed,
   input  logic [LENGTH_BITS-1:0]              bar_length,
   input  cal_load_type                        cal_load,
   output logic                                rsp_both_sides_seen,
   output logic [CHARGE_BITS-1:0]              rsp_corrected_charge,
   output logic signed [POS_BITS-1:0]          rsp_position_um,
   output logic                                rsp_position_updated,
   output logic                                rsp_out_of_range,
   output logic                                rsp_position_cal_active
);

   localparam int DIFF_BITS = diff_width(TIME_BITS);
   localparam int PROD_BITS = DIFF_BITS + SPEED_BITS + 1;

   logic [POS_BITS-1:0]          last_ff;
   logic [POS_BITS-1:0]          last_in;
   logic [FAIL_BITS-1:0]         fail_ff;
   logic [FAIL_BITS-1:0]         fail_in;
   logic                         cal_ff;
   logic                         cal_in;
   logic signed [PROD_BITS-1:0]  prod;
   logic                         fits;
   logic [POS_BITS-1:0]          sat;
   logic [POS_BITS:0]            mag;
   logic                         oor_now;
   logic                         compute;
   logic                         updated;
   logic                         oor;

   always_comb begin
      prod = PROD_BITS'(diff) * PROD_BITS'(signed'({1'b0, speed}));
      fits = (prod[PROD_BITS-1:POS_BITS-1] == {(PROD_BITS-POS_BITS+1){prod[PROD_BITS-1]}});
      if (fits) begin
         sat = prod[POS_BITS-1:0];
      end else begin
         sat = prod[PROD_BITS-1] ? POS_MIN : POS_MAX;
      end
      if (sat[POS_BITS-1]) begin
         mag = (POS_BITS+1)'(0) - {sat[POS_BITS-1], sat};
      end else begin
         mag = {1'b0, sat};
      end
      oor_now = mag > (POS_BITS+1)'(bar_length);
      compute = flags.both_seen && cal_ff;

      last_in = last_ff;
      fail_in = fail_ff;
      cal_in  = cal_ff;
      updated = 1'b0;
      oor     = 1'b0;
      if (flags.clear) begin
         last_in = '0;
      end else if (compute) begin
         last_in = sat;
         updated = 1'b1;
         if (oor_now) begin
            oor = 1'b1;
            if (fail_ff == MAX_FAILS) begin
               fail_in = '0;
               cal_in  = 1'b0;
            end else begin
               fail_in = fail_ff + FAIL_BITS'(1);
            end
         end else begin
            fail_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
         fail_ff <= '0;
         cal_ff  <= 1'b0;
      end else if (cal_load.load) begin
         cal_ff <= cal_load.value;
      end else if (step) begin
         last_ff <= last_in;
         fail_ff <= fail_in;
         cal_ff  <= cal_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_both_sides_seen     <= flags.both_seen;
         rsp_corrected_charge    <= charge;
         rsp_position_um         <= last_in;
         rsp_position_updated    <= updated;
         rsp_out_of_range        <= oor;
         rsp_position_cal_active <= cal_in;
      end
   end

`ifndef SYNTH
   a_fail_bound: assert property (@(posedge clock) disable iff (reset)
      fail_ff <= MAX_FAILS)
      else $error("fail count above limit");

   a_cal_off_cause: assert property (@(posedge clock) disable iff (reset)
      $fell(cal_ff) |-> $past(cal_load.load || (step && compute && oor_now)))
      else $error("calibration switched off without cause");

   a_hold_position: assert property (@(posedge clock) disable iff (reset)
      step && !cal_load.load && !flags.clear && !compute
      |=> rsp_position_um == $past(last_ff))
      else $error("position not held when no position computed");
`endif

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
   import tehp_pkg::*;

   localparam int TIME_BITS   = 20;
   localparam int CHARGE_BITS = 12;
   localparam int TIME_MAX    = (1 << TIME_BITS) - 1;

   // item codes
   localparam logic KIND_HIT   = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;
   localparam logic SIDE_RIGHT = 1'b0;
   localparam logic SIDE_LEFT  = 1'b1;
   localparam logic [1:0] BOTH_SIDES = 2'b11;

   // calibration watchdog and position range
   localparam int     MISS_LIMIT = 10;
   localparam longint POS_HI     = 64'sd2147483647;
   localparam longint POS_LO     = -64'sd2147483648;

   // run shape
   localparam int RANDOM_PHASES    = 10;
   localparam int ITEMS_PER_PHASE  = 133;
   localparam int HOLD_AT          = 900;
   localparam int HOLD_CYCLES      = 300;
   localparam int HOLD_MIN_BACKLOG = 8;
   localparam int SETTLE_CYCLES    = 4;
   localparam int DRAIN_CYCLES     = 8;
   localparam int STALL_LIMIT      = 3000;

   typedef struct packed {
      logic                   kind;
      logic                   side;
      logic [TIME_BITS-1:0]   hit_time;
      logic [CHARGE_BITS-1:0] raw_charge;
   } hit_item_type;

   typedef struct packed {
      logic                   both_seen;
      logic [CHARGE_BITS-1:0] charge;
      logic signed [31:0]     position;
      logic                   updated;
      logic                   out_of_range;
      logic                   cal_active;
   } bar_result_type;

   // clock, reset and block ports
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic                        req_kind = 1'b0;
   logic                        req_side = 1'b0;
   logic [TIME_BITS-1:0]        req_hit_time_ps = '0;
   logic [CHARGE_BITS-1:0]      req_raw_charge = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic                        rsp_both_sides_seen;
   logic [CHARGE_BITS-1:0]      rsp_corrected_charge;
   logic signed [POS_BITS-1:0]  rsp_position_um;
   logic                        rsp_position_updated;
   logic                        rsp_out_of_range;
   logic                        rsp_position_cal_active;
   logic                        csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0]   csr_index = '0;
   logic [CSR_DATA_BITS-1:0]    csr_write_data = '0;

   // register copy, kept in step with every csr write
   logic [11:0]        cfg_ped_right  = 12'd0;
   logic [11:0]        cfg_ped_left   = 12'd0;
   logic signed [20:0] cfg_offset     = 21'sd0;
   logic [9:0]         cfg_speed      = 10'd140;
   logic [20:0]        cfg_wrap       = 21'd1048576;
   logic [23:0]        cfg_bar        = 24'd2700000;

   // predicted block state
   logic [1:0]         pair_seen     = 2'b00;
   logic [20:0]        side_stamp [0:1];
   int                 miss_run      = 0;
   logic               cal_on        = 1'b0;
   logic signed [31:0] held_position = 32'sd0;

   // stimulus and scoreboard
   hit_item_type   hit_backlog[$];
   bar_result_type awaited_results[$];
   hit_item_type   offered;
   int          items_accepted  = 0;
   int          mismatch_count  = 0;
   int          send_idle_pct   = 0;
   int          recv_idle_pct   = 0;
   int          hold_left       = 0;
   logic        hold_done       = 1'b0;
   int          stall_cycles    = 0;

   two_ended_bar_hit_position_unit dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_kind                (req_kind),
      .req_side                (req_side),
      .req_hit_time_ps         (req_hit_time_ps),
      .req_raw_charge          (req_raw_charge),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_both_sides_seen     (rsp_both_sides_seen),
      .rsp_corrected_charge    (rsp_corrected_charge),
      .rsp_position_um         (rsp_position_um),
      .rsp_position_updated    (rsp_position_updated),
      .rsp_out_of_range        (rsp_out_of_range),
      .rsp_position_cal_active (rsp_position_cal_active),
      .csr_write_enable        (csr_write_enable),
      .csr_index               (csr_index),
      .csr_write_data          (csr_write_data)
   );

   always #10 clock = ~clock;

   // pairs the hit with the other side and works out the entry position
   function automatic bar_result_type predict_pair_position(hit_item_type it);
      bar_result_type r;
      longint ped, chg, tl, tr, d, diff, pos, mag;
      r   = '0;
      chg = 0;
      if (it.kind == KIND_CLEAR) begin
         pair_seen     = 2'b00;
         held_position = 32'sd0;
      end else begin
         ped = (it.side == SIDE_LEFT) ? longint'(cfg_ped_left) : longint'(cfg_ped_right);
         // pedestal subtraction, never below one
         chg = (longint'(it.raw_charge) > ped) ? longint'(it.raw_charge) - ped : 1;
         pair_seen[it.side]  = 1'b1;
         side_stamp[it.side] = 21'(it.hit_time);
         if (pair_seen == BOTH_SIDES) begin
            tl = longint'(side_stamp[SIDE_LEFT]);
            tr = longint'(side_stamp[SIDE_RIGHT]);
            d  = (tl > tr) ? tl - tr : tr - tl;
            // more than half a period apart: push the earlier stamp one period on
            if (2 * d > longint'(cfg_wrap)) begin
               if (tl < tr)
                  side_stamp[SIDE_LEFT] = 21'(tl + longint'(cfg_wrap));
               else
                  side_stamp[SIDE_RIGHT] = 21'(tr + longint'(cfg_wrap));
            end
            if (cal_on) begin
               diff = longint'(side_stamp[SIDE_LEFT]) - longint'(side_stamp[SIDE_RIGHT])
                      - longint'(cfg_offset);
               pos  = diff * longint'(cfg_speed);
               if (pos > POS_HI) pos = POS_HI;
               if (pos < POS_LO) pos = POS_LO;
               held_position = 32'(pos);
               r.updated     = 1'b1;
               mag = (pos < 0) ? -pos : pos;
               if (mag > longint'(cfg_bar)) begin
                  r.out_of_range = 1'b1;
                  miss_run++;
                  // too many implausible positions in a row: calibration off
                  if (miss_run > MISS_LIMIT) begin
                     miss_run = 0;
                     cal_on   = 1'b0;
                  end
               end else begin
                  miss_run = 0;
               end
            end
         end
      end
      r.both_seen  = (pair_seen == BOTH_SIDES);
      r.charge     = CHARGE_BITS'(chg);
      r.position   = held_position;
      r.cal_active = cal_on;
      return r;
   endfunction

   function automatic bit busy();
      return hit_backlog.size() != 0 || awaited_results.size() != 0 || req_valid;
   endfunction

   task automatic push_item(logic kind, logic side, logic [TIME_BITS-1:0] t,
                            logic [CHARGE_BITS-1:0] q);
      hit_item_type it;
      it.kind       = kind;
      it.side       = side;
      it.hit_time   = t;
      it.raw_charge = q;
      hit_backlog = {hit_backlog, it};
   endtask

   // settle everything in flight, then come back aligned to a rising edge
   task automatic wait_idle();
      do @(negedge clock); while (busy());
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one register write per cycle, enable stays high across back-to-back writes
   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      case (idx)
         CSR_PEDESTAL_RIGHT: cfg_ped_right = value[11:0];
         CSR_PEDESTAL_LEFT:  cfg_ped_left  = value[11:0];
         CSR_TIME_OFFSET:    cfg_offset    = value[20:0];
         CSR_SPEED:          cfg_speed     = value[9:0];
         CSR_WRAP_PERIOD:    cfg_wrap      = value[20:0];
         CSR_BAR_LENGTH:     cfg_bar       = value[23:0];
         // loading the enable also reloads the active flag
         CSR_POS_CAL_ENABLE: cal_on        = value[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic apply_setting(logic [11:0] ped_r, logic [11:0] ped_l,
                                logic signed [20:0] offset, logic [9:0] speed,
                                logic [20:0] wrap, logic [23:0] bar, logic cal);
      wait_idle();
      write_reg(CSR_PEDESTAL_RIGHT, 24'(ped_r));
      write_reg(CSR_PEDESTAL_LEFT, 24'(ped_l));
      write_reg(CSR_TIME_OFFSET, 24'(offset));
      write_reg(CSR_SPEED, 24'(speed));
      write_reg(CSR_WRAP_PERIOD, 24'(wrap));
      write_reg(CSR_BAR_LENGTH, 24'(bar));
      write_reg(CSR_POS_CAL_ENABLE, 24'(cal));
      csr_write_enable <= 1'b0;
   endtask

   // idle pattern follows the thirds of the run
   task automatic set_idle(int phase);
      case (phase * 3 / (RANDOM_PHASES + 1))
         0: begin send_idle_pct = 35; recv_idle_pct = 62; end
         1: begin send_idle_pct = 62; recv_idle_pct = 35; end
         default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
   endtask

   // mostly complete events (two sides, maybe a re-hit, then clear), rest noise
   task automatic queue_random_items(int count);
      int   pushed, span, lim, target, t_first, t_second;
      logic first_side;
      pushed = 0;
      while (pushed < count) begin
         if ($urandom_range(99) < 70) begin
            // aim the time difference around the plausible position range
            span = (cfg_speed == 0) ? 5000 : int'(cfg_bar) / int'(cfg_speed) + 1;
            if (span > 600000) span = 600000;
            lim        = span + span / 4;
            target     = int'($urandom_range(2 * lim)) - lim;
            first_side = 1'($urandom_range(1));
            t_first    = int'($urandom_range(TIME_MAX));
            if ($urandom_range(9) == 0)
               t_second = int'($urandom_range(TIME_MAX));
            else if (first_side == SIDE_RIGHT)
               t_second = t_first + target + int'(cfg_offset);
            else
               t_second = t_first - target - int'(cfg_offset);
            push_item(KIND_HIT, first_side, TIME_BITS'(t_first),
                      CHARGE_BITS'($urandom_range(4095)));
            push_item(KIND_HIT, !first_side, TIME_BITS'(t_second),
                      CHARGE_BITS'($urandom_range(4095)));
            pushed += 2;
            if ($urandom_range(4) == 0) begin
               push_item(KIND_HIT, 1'($urandom_range(1)),
                         TIME_BITS'(t_second + int'($urandom_range(200))),
                         CHARGE_BITS'($urandom_range(4095)));
               pushed++;
            end
            // now and then the event is left open
            if ($urandom_range(9) != 0) begin
               push_item(KIND_CLEAR, 1'($urandom_range(1)),
                         TIME_BITS'($urandom_range(TIME_MAX)),
                         CHARGE_BITS'($urandom_range(4095)));
               pushed++;
            end
         end else begin
            push_item(($urandom_range(9) < 3) ? KIND_CLEAR : KIND_HIT,
                      1'($urandom_range(1)), TIME_BITS'($urandom_range(TIME_MAX)),
                      CHARGE_BITS'($urandom_range(4095)));
            pushed++;
         end
      end
   endtask

   task automatic note_mismatch(string field, longint want, longint got);
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      mismatch_count++;
   endtask

   task automatic check_result();
      bar_result_type want;
      if (awaited_results.size() == 0) begin
         $display("%0t: result transaction with no expectation waiting", $time);
         mismatch_count++;
      end else begin
         want = awaited_results.pop_front();
         if (rsp_both_sides_seen !== want.both_seen)
            note_mismatch("both_sides_seen", want.both_seen, rsp_both_sides_seen);
         if (rsp_corrected_charge !== want.charge)
            note_mismatch("corrected_charge", want.charge, rsp_corrected_charge);
         if (rsp_position_um !== want.position)
            note_mismatch("position_um", longint'(want.position), longint'(rsp_position_um));
         if (rsp_position_updated !== want.updated)
            note_mismatch("position_updated", want.updated, rsp_position_updated);
         if (rsp_out_of_range !== want.out_of_range)
            note_mismatch("out_of_range", want.out_of_range, rsp_out_of_range);
         if (rsp_position_cal_active !== want.cal_active)
            note_mismatch("position_cal_active", want.cal_active, rsp_position_cal_active);
      end
   endtask

   // request driver: predicts on acceptance, then offers the next item or idles
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            awaited_results = {awaited_results, predict_pair_position(offered)};
            items_accepted++;
         end
         // payload only moves once the held transaction is gone
         if (!req_valid || req_ready) begin
            if (hit_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered         = hit_backlog.pop_front();
               req_valid       <= 1'b1;
               req_kind        <= offered.kind;
               req_side        <= offered.side;
               req_hit_time_ps <= offered.hit_time;
               req_raw_charge  <= offered.raw_charge;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor: checks each transaction, throttles ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_result();
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (!hold_done && items_accepted >= HOLD_AT
                      && hit_backlog.size() > HOLD_MIN_BACKLOG) begin
            // one long back-pressure stretch so the pipeline fills and stalls input
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // watchdog on cycles with work outstanding and no transaction on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || !busy()) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int                 phase;
      logic signed [20:0] rnd_offset;
      logic [20:0]        rnd_wrap;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: charge clamps, unwrap both ways, equal times, range edges
      apply_setting(12'd100, 12'hFFF, 21'sd0, 10'd140, 21'd1048576, 24'd2700000, 1'b1);
      set_idle(0);
      push_item(KIND_CLEAR, SIDE_LEFT, 20'hFFFFF, 12'hFFF);
      push_item(KIND_HIT, SIDE_RIGHT, 20'd0, 12'd0);
      push_item(KIND_HIT, SIDE_LEFT, 20'hFFFFF, 12'hFFF);   // far apart, right unwrapped
      push_item(KIND_HIT, SIDE_RIGHT, 20'd100, 12'd101);    // one above pedestal
      push_item(KIND_CLEAR, SIDE_RIGHT, 20'd0, 12'd0);
      push_item(KIND_HIT, SIDE_LEFT, 20'd5000, 12'hFFF);    // one side only
      push_item(KIND_HIT, SIDE_RIGHT, 20'd5000, 12'hFFF);   // equal times
      push_item(KIND_CLEAR, SIDE_LEFT, 20'd0, 12'd0);
      push_item(KIND_HIT, SIDE_RIGHT, 20'd1000, 12'd50);
      push_item(KIND_HIT, SIDE_LEFT, 20'd20286, 12'd50);    // just past bar length
      push_item(KIND_HIT, SIDE_LEFT, 20'd20285, 12'd50);    // just inside
      push_item(KIND_CLEAR, SIDE_RIGHT, 20'hFFFFF, 12'hFFF);
      push_item(KIND_HIT, SIDE_RIGHT, 20'd0, 12'd2000);
      push_item(KIND_HIT, SIDE_LEFT, 20'd524288, 12'd2000); // exactly half period
      push_item(KIND_CLEAR, SIDE_LEFT, 20'd0, 12'd0);
      push_item(KIND_HIT, SIDE_LEFT, 20'd0, 12'd3000);
      push_item(KIND_HIT, SIDE_RIGHT, 20'd524289, 12'd3000); // left unwrapped
      push_item(KIND_CLEAR, SIDE_RIGHT, 20'd0, 12'd0);
      push_item(KIND_HIT, SIDE_RIGHT, 20'd0, 12'd4095);
      push_item(KIND_HIT, SIDE_LEFT, 20'd524289, 12'd0);    // right unwrapped
      push_item(KIND_CLEAR, SIDE_LEFT, 20'hFFFFF, 12'hFFF);

      for (phase = 1; phase <= RANDOM_PHASES; phase++) begin
         rnd_offset = 21'(int'($urandom_range(4000)) - 2000);
         rnd_wrap   = ($urandom_range(3) == 0) ? 21'd1048576 : 21'($urandom_range(1048576, 1));
         case (phase)
            1: apply_setting(12'($urandom_range(4095)), 12'($urandom_range(4095)), 21'sd0,
                             10'd140, 21'd1048576, 24'd2700000, 1'b1);
            // extremes: widest pedestals, most negative offset, fastest, tiny wrap
            2: apply_setting(12'hFFF, 12'hFFF, 21'h100000, 10'd1023, 21'd1,
                             24'hFFFFFF, 1'b1);
            3: apply_setting(12'd0, 12'd0, 21'h0FFFFF, 10'd0, 21'd1048576, 24'd0, 1'b1);
            // zero bar length: every nonzero position fails, calibration drops out
            4: apply_setting(12'($urandom_range(4095)), 12'($urandom_range(4095)), rnd_offset,
                             10'd140, 21'd1048576, 24'd0, 1'b1);
            5: apply_setting(12'($urandom_range(4095)), 12'($urandom_range(4095)), rnd_offset,
                             10'($urandom_range(1023)), rnd_wrap,
                             24'($urandom_range(5000000)), 1'b0);
            default: begin
               if ($urandom_range(3) == 0) rnd_offset = 21'($urandom);
               apply_setting(12'($urandom_range(4095)), 12'($urandom_range(4095)), rnd_offset,
                             10'($urandom_range(1023)), rnd_wrap,
                             24'($urandom_range(5000000)), 1'b1);
            end
         endcase
         set_idle(phase);
         queue_random_items(ITEMS_PER_PHASE);
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && awaited_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/tehp_pkg.sv
sv/tehp_pair.sv
sv/tehp_pos.sv
sv/two_ended_bar_hit_position_unit.sv
sim/tb_top.sv
